### design/ffa_pkg.sv
package ffa_pkg;

  localparam int NumEntries = 64;
  localparam int OffW       = 32;
  localparam int IdxW       = $clog2(NumEntries);
  localparam int CntW       = $clog2(NumEntries + 1);
  localparam int SizeW      = 32;
  localparam int AlignW     = 32;
  localparam int BlkIdxW    = 6;
  localparam int RegionW    = 32;

  localparam logic [RegionW-1:0] RegionReset = RegionW'(1) << 27;

  typedef enum logic [0:0] {
    OpAlloc = 1'b0,
    OpFree  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StRegion  = 2'd1,
    StFull    = 2'd2,
    StUnknown = 2'd3
  } status_e;

  typedef struct packed {
    logic [0:0]         opcode;
    logic [SizeW-1:0]   request_size;
    logic [AlignW-1:0]  alignment;
    logic [BlkIdxW-1:0] block_index;
  } ffa_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [BlkIdxW-1:0] granted_index;
    logic [31:0]        granted_offset;
  } ffa_out_t;

endpackage

### design/first_fit_aligned_block_allocator_top.sv
// Free: the result is registered on acceptance. Allocate: an entry rejected by its active
// mark or size passes SRead and SCheck; one that reaches the alignment test adds SDiv and
// SFit; appending uses SAppStart/SAppDiv/SAppChk. Both share the bit-serial remainder unit.
// One transaction at a time: the input stalls until the result is taken.
// Reset clears all active marks and the entry count and loads region_q with 1<<27;
// table contents are undefined until written and need no clearing pass.
module first_fit_aligned_block_allocator_top import ffa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ffa_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ffa_out_t           out_data_o,
  input  logic               cfg_we_i,
  input  logic [RegionW-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    SIdle,
    SRead,
    SCheck,
    SDiv,
    SFit,
    SAppStart,
    SAppDiv,
    SAppChk
  } state_e;

  localparam logic [OffW+1:0] OffLimit = (OffW + 2)'((64'(1) << OffW) - 64'(1));

  state_e               state_q;
  ffa_in_t              item_q;
  logic [AlignW-1:0]    align_q;
  logic [IdxW-1:0]      idx_q;
  logic [CntW-1:0]      cnt_q;
  logic [NumEntries-1:0] active_q;
  logic [OffW-1:0]      max_end_q;
  logic [AlignW-1:0]    pad_q;
  logic [OffW:0]        app_q;
  logic [RegionW-1:0]   region_q;
  ffa_out_t             out_q;
  logic                 out_valid_q;

  logic                 ram_we;
  logic                 ram_re;
  logic [OffW+SizeW-1:0] ram_rdata;
  logic [OffW-1:0]      rd_off;
  logic [SizeW-1:0]     rd_size;
  logic [OffW:0]        rd_end;
  logic                 candidate;
  logic                 last_entry;
  logic                 rem_start;
  logic [OffW-1:0]      rem_dvd;
  logic                 rem_done;
  logic [AlignW-1:0]    rem_val;
  logic [AlignW-1:0]    pad_d;
  logic [AlignW:0]      need;
  logic                 fits;
  logic [OffW+1:0]      app_sum;
  logic                 over;
  logic                 full;
  logic                 accept;
  logic                 free_known;

  assign accept     = in_valid_i && !in_stall_o;
  assign rd_off     = ram_rdata[OffW+SizeW-1:SizeW];
  assign rd_size    = ram_rdata[SizeW-1:0];
  assign rd_end     = {1'b0, rd_off} + (OffW + 1)'(rd_size);
  assign candidate  = !active_q[idx_q] && (rd_size >= item_q.request_size);
  assign last_entry = (CntW'(idx_q) + CntW'(1)) == cnt_q;
  assign pad_d      = (rem_val == '0) ? '0 : (align_q - rem_val);
  assign need       = {1'b0, pad_q} + (AlignW + 1)'(item_q.request_size);
  assign fits       = (AlignW + 1)'(rd_size) >= need;
  assign app_sum    = {1'b0, app_q} + (OffW + 2)'(item_q.request_size);
  assign over       = (app_sum > (OffW + 2)'(region_q)) || (app_sum > OffLimit);
  assign full       = cnt_q == CntW'(NumEntries);
  assign free_known = CntW'(in_data_i.block_index) < cnt_q;

  assign ram_re    = state_q == SRead;
  assign ram_we    = (state_q == SAppChk) && !over && !full;
  assign rem_start = ((state_q == SCheck) && candidate) || (state_q == SAppStart);
  assign rem_dvd   = (state_q == SCheck) ? rd_off : max_end_q;

  ffa_ram #(
    .Width(OffW + SizeW),
    .Depth(NumEntries)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_q[IdxW-1:0]),
    .wdata_i({app_q[OffW-1:0], item_q.request_size}),
    .re_i   (ram_re),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  ffa_rem u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (rem_start),
    .dividend_i(rem_dvd),
    .divisor_i (align_q),
    .done_o    (rem_done),
    .rem_o     (rem_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      item_q      <= '0;
      align_q     <= AlignW'(1);
      idx_q       <= '0;
      cnt_q       <= '0;
      active_q    <= '0;
      max_end_q   <= '0;
      pad_q       <= '0;
      app_q       <= '0;
      region_q    <= RegionReset;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        region_q <= cfg_data_i;
      end
      case (state_q)
        SIdle: begin
          if (accept) begin
            item_q    <= in_data_i;
            align_q   <= (in_data_i.alignment == '0) ? AlignW'(1) : in_data_i.alignment;
            idx_q     <= '0;
            max_end_q <= '0;
            if (in_data_i.opcode == OpFree) begin
              out_q.granted_index  <= '0;
              out_q.granted_offset <= '0;
              if (free_known) begin
                active_q[IdxW'(in_data_i.block_index)] <= 1'b0;
                out_q.status <= StOk;
              end else begin
                out_q.status <= StUnknown;
              end
              out_valid_q <= 1'b1;
              state_q     <= SIdle;
            end else if (cnt_q == '0) begin
              state_q <= SAppStart;
            end else begin
              state_q <= SRead;
            end
          end
        end
        SRead: begin
          state_q <= SCheck;
        end
        SCheck: begin
          if (rd_end > (OffW + 1)'(max_end_q)) begin
            max_end_q <= rd_end[OffW-1:0];
          end
          if (candidate) begin
            state_q <= SDiv;
          end else if (last_entry) begin
            state_q <= SAppStart;
          end else begin
            idx_q   <= idx_q + IdxW'(1);
            state_q <= SRead;
          end
        end
        SDiv: begin
          if (rem_done) begin
            pad_q   <= pad_d;
            state_q <= SFit;
          end
        end
        SFit: begin
          if (fits) begin
            active_q[idx_q]      <= 1'b1;
            out_q.status         <= StOk;
            out_q.granted_index  <= BlkIdxW'(idx_q);
            out_q.granted_offset <= 32'(rd_off + OffW'(pad_q));
            out_valid_q          <= 1'b1;
            state_q              <= SIdle;
          end else if (last_entry) begin
            state_q <= SAppStart;
          end else begin
            idx_q   <= idx_q + IdxW'(1);
            state_q <= SRead;
          end
        end
        SAppStart: begin
          state_q <= SAppDiv;
        end
        SAppDiv: begin
          if (rem_done) begin
            app_q   <= {1'b0, max_end_q} + (OffW + 1)'(pad_d);
            state_q <= SAppChk;
          end
        end
        SAppChk: begin
          out_q.granted_index  <= '0;
          out_q.granted_offset <= '0;
          if (over) begin
            out_q.status <= StRegion;
          end else if (full) begin
            out_q.status <= StFull;
          end else begin
            active_q[cnt_q[IdxW-1:0]] <= 1'b1;
            cnt_q                     <= cnt_q + CntW'(1);
            out_q.status              <= StOk;
            out_q.granted_index       <= BlkIdxW'(cnt_q[IdxW-1:0]);
            out_q.granted_offset      <= 32'(app_q);
          end
          out_valid_q <= 1'b1;
          state_q     <= SIdle;
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = (state_q != SIdle) || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### design/ffa_ram.sv
module ffa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/ffa_rem.sv
module ffa_rem import ffa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [OffW-1:0]   dividend_i,
  input  logic [AlignW-1:0] divisor_i,
  output logic              done_o,
  output logic [AlignW-1:0] rem_o
);

  localparam int CntBits = $clog2(OffW);

  logic               busy_q;
  logic               done_q;
  logic [CntBits-1:0] cnt_q;
  logic [OffW-1:0]    dvd_q;
  logic [AlignW-1:0]  dvs_q;
  logic [AlignW-1:0]  rem_q;
  logic [AlignW:0]    shifted;
  logic [AlignW:0]    diff;
  logic [AlignW-1:0]  rem_d;

  always_comb begin
    shifted = {rem_q, dvd_q[OffW-1]};
    diff    = shifted - {1'b0, dvs_q};
    if (shifted >= {1'b0, dvs_q}) begin
      rem_d = diff[AlignW-1:0];
    end else begin
      rem_d = shifted[AlignW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        dvd_q  <= dividend_i;
        dvs_q  <= divisor_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        dvd_q <= dvd_q << 1;
        rem_q <= rem_d;
        cnt_q <= cnt_q + CntBits'(1);
        if (cnt_q == CntBits'(OffW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### tb/first_fit_aligned_block_allocator_top_tb.sv
module first_fit_aligned_block_allocator_top_tb;
  import ffa_pkg::*;

  localparam longint unsigned OffsetLimit = (64'd1 << OffW) - 1;
  localparam int CycleLimit  = 20_000_000;
  localparam int DrainCycles = 2500;
  localparam int LongHoldAt  = 1500;
  localparam int LongHoldLen = 400;

  logic               clk_i    = 1'b0;
  logic               rst_ni   = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  ffa_in_t            in_data  = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ffa_out_t           out_data;
  logic               cfg_we   = 1'b0;
  logic [RegionW-1:0] cfg_data = '0;

  first_fit_aligned_block_allocator_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  initial forever #6 clk_i = ~clk_i;

  // Allocator table as predicted from accepted transactions.
  longint unsigned blk_off  [NumEntries];
  longint unsigned blk_size [NumEntries];
  bit              blk_active [NumEntries];
  int              blk_count    = 0;
  longint unsigned region_bytes = 64'(RegionReset);

  ffa_in_t  pending_reqs [$];
  ffa_out_t expected_grants [$];
  ffa_out_t want;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_cnt  = 0;
  int results_seen  = 0;
  int hold_left     = 0;
  bit long_hold_done = 1'b0;
  int cycle_cnt     = 0;

  function automatic longint unsigned round_to(longint unsigned v, longint unsigned a);
    longint unsigned q;
    q = v / a;
    if (v % a != 0) q++;
    return q * a;
  endfunction

  function automatic ffa_out_t alloc_or_free(ffa_in_t t);
    ffa_out_t        r;
    longint unsigned req, algn, end_off, top, aligned;
    int              i;
    r = '0;
    if (t.opcode == OpFree) begin
      if (int'(t.block_index) >= blk_count) begin
        r.status = StUnknown;
      end else begin
        blk_active[t.block_index] = 1'b0;
        r.status = StOk;
      end
      return r;
    end
    req  = 64'(t.request_size);
    algn = (t.alignment == 0) ? 64'd1 : 64'(t.alignment);
    top  = 0;
    for (i = 0; i < blk_count; i++) begin
      end_off = blk_off[i] + blk_size[i];
      if (end_off > top) top = end_off;
      if (!blk_active[i] && blk_size[i] >= req) begin
        aligned = round_to(blk_off[i], algn);
        if (blk_size[i] >= (aligned - blk_off[i]) + req) begin
          blk_active[i]    = 1'b1;
          r.status         = StOk;
          r.granted_index  = BlkIdxW'(i);
          r.granted_offset = 32'(aligned);
          return r;
        end
      end
    end
    top = round_to(top, algn);
    if (top + req > region_bytes || top + req > OffsetLimit) begin
      r.status = StRegion;
    end else if (blk_count >= NumEntries) begin
      r.status = StFull;
    end else begin
      blk_off[blk_count]    = top;
      blk_size[blk_count]   = req;
      blk_active[blk_count] = 1'b1;
      r.status         = StOk;
      r.granted_index  = BlkIdxW'(blk_count);
      r.granted_offset = 32'(top);
      blk_count++;
    end
    return r;
  endfunction

  function automatic ffa_in_t mk_alloc(logic [SizeW-1:0] sz, logic [AlignW-1:0] al);
    ffa_in_t t;
    t = '0;
    t.opcode       = OpAlloc;
    t.request_size = sz;
    t.alignment    = al;
    return t;
  endfunction

  function automatic ffa_in_t mk_free(logic [BlkIdxW-1:0] idx);
    ffa_in_t t;
    t = '0;
    t.opcode      = OpFree;
    t.block_index = idx;
    return t;
  endfunction

  function automatic ffa_in_t random_request();
    ffa_in_t t;
    int      pick;
    int      hi;
    t.request_size = $urandom();
    t.alignment    = $urandom();
    t.block_index  = BlkIdxW'($urandom_range(0, NumEntries - 1));
    if ($urandom_range(99) < 55) begin
      t.opcode = OpAlloc;
      pick = $urandom_range(99);
      if (pick < 70)      t.request_size = $urandom_range(0, 256);
      else if (pick < 90) t.request_size = $urandom_range(0, 4096);
      pick = $urandom_range(99);
      if (pick < 50)      t.alignment = 32'd1 << $urandom_range(0, 6);
      else if (pick < 80) t.alignment = $urandom_range(1, 100);
      else if (pick < 95) t.alignment = 32'd1 << $urandom_range(0, 31);
    end else begin
      t.opcode = OpFree;
      hi = (blk_count > NumEntries - 1) ? NumEntries - 1 : blk_count;
      if ($urandom_range(99) < 85) t.block_index = BlkIdxW'($urandom_range(0, hi));
    end
    return t;
  endfunction

  task automatic note_mismatch(string msg);
    $display("ERROR: %s", msg);
    mismatch_cnt++;
  endtask

  task automatic queue_req(ffa_in_t t);
    pending_reqs.insert(pending_reqs.size(), t);
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || expected_grants.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_region(logic [RegionW-1:0] v);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we       <= 1'b0;
    region_bytes = 64'(v);
  endtask

  task automatic set_idle_mode(int m);
    case (m)
      0: begin
        send_idle_pct = 33;
        recv_idle_pct = 83;
      end
      1: begin
        send_idle_pct = 83;
        recv_idle_pct = 33;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // Sender: predict each accepted transaction, hold the payload while stalled.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall)
        expected_grants.insert(expected_grants.size(), alloc_or_free(in_data));
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted result against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_grants.size() == 0) begin
          note_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
        end else begin
          want = expected_grants.pop_front();
          if (out_data.status !== want.status)
            note_mismatch($sformatf("result %0d status: got %0d expected %0d",
                                    results_seen, out_data.status, want.status));
          if (out_data.granted_index !== want.granted_index)
            note_mismatch($sformatf("result %0d granted_index: got %0d expected %0d",
                                    results_seen, out_data.granted_index,
                                    want.granted_index));
          if (out_data.granted_offset !== want.granted_offset)
            note_mismatch($sformatf("result %0d granted_offset: got %0h expected %0h",
                                    results_seen, out_data.granted_offset,
                                    want.granted_offset));
        end
      end
      if (!long_hold_done && results_seen >= LongHoldAt) begin
        hold_left      = LongHoldLen;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [RegionW-1:0] phase_region [4];
    int                 phase_items  [4];
    int                 phase_mode   [4];
    int                 p, n;
    phase_region[0] = '0;
    phase_region[1] = 32'd40000;
    phase_region[2] = 32'hFFFF_FFFF;
    phase_region[3] = $urandom_range(60000, 32'hFFFF_FFFF);
    phase_items     = '{40, 560, 560, 580};
    phase_mode      = '{0, 0, 1, 2};
    set_idle_mode(0);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_req(mk_free(6'd0));
    queue_req(mk_alloc(32'd100, 32'd0));
    queue_req(mk_alloc(32'd0, 32'd1));
    queue_req(mk_alloc(32'd50, 32'd64));
    queue_req(mk_alloc(32'd1000, 32'd4096));
    queue_req(mk_free(6'd0));
    queue_req(mk_free(6'd0));
    queue_req(mk_alloc(32'd10, 32'd16));
    queue_req(mk_free(6'd3));
    queue_req(mk_alloc(32'd900, 32'd1000));
    queue_req(mk_alloc(32'd1, 32'd4097));
    queue_req(mk_free(6'd63));
    queue_req(mk_alloc(32'hFFFF_FFFF, 32'd1));
    queue_req(mk_alloc(RegionReset - 32'd6900 + 32'd1, 32'd1));
    queue_req(mk_alloc(RegionReset - 32'd6900, 32'd1));
    queue_req(mk_alloc(32'd0, 32'hFFFF_FFFF));
    queue_req(mk_free(6'd1));
    queue_req(mk_alloc(32'd0, 32'h8000_0000));
    queue_req(mk_free(6'd5));
    queue_req(mk_alloc(32'd5, 32'd3));

    for (p = 0; p < 4; p++) begin
      wait_idle();
      write_region(phase_region[p]);
      set_idle_mode(phase_mode[p]);
      for (n = 0; n < phase_items[p]; n++) begin
        while (pending_reqs.size() >= 2) @(negedge clk_i);
        queue_req(random_request());
      end
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_grants.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", expected_grants.size()));
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
